FILE: rtl/core/assert_macros.svh
// assertion macros used by the core top level
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// ante true at an edge requires cons at that same edge
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// ante true at an edge requires cons at the next edge
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error("next cycle check failed");

// cond must never hold
`define ASSERT_NEVER(label, clk, rst_n, cond) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
		else $error("forbidden condition seen");

`endif

FILE: rtl/core/bht_pkg.sv
// types and constants of the bucketed hash table
`timescale 1ns / 1ps

package bht_pkg;

	localparam int HASH_W      = 32;
	localparam int DATA_W      = 32;
	localparam int SIZE_DEF    = 16;
	localparam int QUEUE_DEPTH = 2;
	localparam int NIB_W       = 4;
	localparam int MOD_STEPS   = HASH_W / NIB_W;
	localparam int STEP_W      = $clog2(MOD_STEPS);

	typedef enum logic [1:0] {
		OP_INSERT = 2'd0,
		OP_FIND   = 2'd1,
		OP_REMOVE = 2'd2
	} op_t;

	typedef enum logic [1:0] {
		F_IDLE,
		F_MOD,
		F_PUSH
	} front_state_t;

	typedef enum logic [1:0] {
		B_CLEAR,
		B_IDLE,
		B_SCAN
	} back_state_t;

	typedef struct packed {
		logic              fail;
		op_t               op;
		logic [HASH_W-1:0] hash;
		logic [DATA_W-1:0] data;
	} req_t;

endpackage

FILE: rtl/core/bht_front.sv
// front end: takes an item, classifies it and works out its bucket
`timescale 1ns / 1ps

module bht_front #(
	parameter int SIZE = bht_pkg::SIZE_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	input  logic [1:0]                           req_type,
	input  logic [bht_pkg::HASH_W-1:0]           key_hash,
	input  logic [bht_pkg::DATA_W-1:0]           data_value,
	input  logic                                 clearing,
	input  logic                                 q_full,
	output logic                                 busy,
	output logic                                 push,
	output bht_pkg::req_t                        req,
	output logic [$clog2(SIZE)-1:0]              bucket
);

	localparam int IDX_W = $clog2(SIZE);
	localparam int T_W   = IDX_W + bht_pkg::NIB_W;

	bht_pkg::front_state_t         state_q, state_d;
	bht_pkg::req_t                 req_q;
	logic [bht_pkg::HASH_W-1:0]    sh_q;
	logic [IDX_W-1:0]              rem_q, rem_d;
	logic [bht_pkg::STEP_W-1:0]    step_q;
	logic [T_W-1:0]                t;
	logic                          accept;
	logic                          op_ok;

	assign busy   = (state_q != bht_pkg::F_IDLE) || clearing;
	assign accept = start && !busy;
	assign op_ok  = (req_type == bht_pkg::OP_INSERT) || (req_type == bht_pkg::OP_FIND) ||
		(req_type == bht_pkg::OP_REMOVE);

	// remainder by SIZE, one nibble of the hash per step
	always_comb begin
		t = {rem_q, sh_q[bht_pkg::HASH_W-1 -: bht_pkg::NIB_W]};
		for (int i = bht_pkg::NIB_W - 1; i >= 0; i--) begin
			if (t >= (T_W'(SIZE) << i)) begin
				t = t - (T_W'(SIZE) << i);
			end
		end
		rem_d = t[IDX_W-1:0];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bht_pkg::F_IDLE: begin
				if (accept) state_d = bht_pkg::F_MOD;
			end
			bht_pkg::F_MOD: begin
				if (step_q == bht_pkg::STEP_W'(bht_pkg::MOD_STEPS - 1)) state_d = bht_pkg::F_PUSH;
			end
			bht_pkg::F_PUSH: begin
				if (!q_full) state_d = bht_pkg::F_IDLE;
			end
			default: state_d = bht_pkg::F_IDLE;
		endcase
	end

	always_comb begin
		push   = (state_q == bht_pkg::F_PUSH) && !q_full;
		req    = req_q;
		bucket = rem_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bht_pkg::F_IDLE;
			step_q  <= '0;
		end else begin
			state_q <= state_d;
			if (accept) begin
				step_q <= '0;
			end else if (state_q == bht_pkg::F_MOD) begin
				step_q <= step_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_q.fail <= (key_hash == '0) || !op_ok;
			req_q.op   <= bht_pkg::op_t'(req_type);
			req_q.hash <= key_hash;
			req_q.data <= data_value;
			sh_q       <= key_hash;
			rem_q      <= '0;
		end else if (state_q == bht_pkg::F_MOD) begin
			sh_q  <= sh_q << bht_pkg::NIB_W;
			rem_q <= rem_d;
		end
	end

endmodule

FILE: rtl/core/bht_queue.sv
// small fifo between the front end and the table engine
`timescale 1ns / 1ps

module bht_queue #(
	parameter int W     = 1,
	parameter int DEPTH = bht_pkg::QUEUE_DEPTH
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  logic [W-1:0]  wdata,
	input  logic          pop,
	output logic          full,
	output logic          empty,
	output logic [W-1:0]  rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [W-1:0]     mem_q [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == CNT_W'(DEPTH));
	assign empty = (cnt_q == '0);
	assign rdata = mem_q[rd_q];

	always_ff @(posedge clk) begin
		if (push) mem_q[wr_q] <= wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wr_q <= (wr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_q + 1'b1;
			if (pop) rd_q <= (rd_q == PTR_W'(DEPTH - 1)) ? '0 : rd_q + 1'b1;
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

FILE: rtl/core/bht_back.sv
// table engine: clears the store, scans a bucket and writes back
`timescale 1ns / 1ps

module bht_back #(
	parameter int SIZE = bht_pkg::SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	input  bht_pkg::req_t                 q_req,
	input  logic [$clog2(SIZE)-1:0]       q_bucket,
	output logic                          pop,
	output logic                          clearing,
	output logic                          done,
	output logic                          success,
	output logic [bht_pkg::DATA_W-1:0]    found_data
);

	localparam int IDX_W  = $clog2(SIZE);
	localparam int SLOTS  = SIZE * SIZE;
	localparam int SLOT_W = $clog2(SLOTS);

	logic [bht_pkg::HASH_W-1:0] hash_mem [SLOTS];
	logic [bht_pkg::DATA_W-1:0] data_mem [SLOTS];

	bht_pkg::back_state_t       state_q, state_d;
	bht_pkg::op_t               op_q;
	logic [bht_pkg::HASH_W-1:0] hash_q;
	logic [bht_pkg::DATA_W-1:0] data_q;
	logic [SLOT_W-1:0]          base_q, base_d;
	logic [IDX_W-1:0]           k_q;
	logic [SLOT_W-1:0]          clr_q;
	logic [bht_pkg::HASH_W-1:0] hrd_q;
	logic [bht_pkg::DATA_W-1:0] drd_q;
	logic                       done_q, success_q;
	logic [bht_pkg::DATA_W-1:0] found_q;

	logic [bht_pkg::HASH_W-1:0] want;
	logic                       hit, last, scanning;
	logic [SLOT_W-1:0]          cur_addr, raddr, waddr;
	logic                       rd_en, we_h, we_d;
	logic [bht_pkg::HASH_W-1:0] wdata_h;
	logic                       res_valid, res_success;
	logic [bht_pkg::DATA_W-1:0] res_data;

	assign base_d   = SLOT_W'(SLOT_W'(q_bucket) * SLOT_W'(SIZE));
	assign cur_addr = base_q + SLOT_W'(k_q);
	assign scanning = (state_q == bht_pkg::B_SCAN);
	// insert looks for an empty slot, find and remove for the key
	assign want     = (op_q == bht_pkg::OP_INSERT) ? '0 : hash_q;
	assign hit      = (hrd_q == want);
	assign last     = (k_q == IDX_W'(SIZE - 1));
	assign clearing = (state_q == bht_pkg::B_CLEAR);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			bht_pkg::B_CLEAR: begin
				if (clr_q == SLOT_W'(SLOTS - 1)) state_d = bht_pkg::B_IDLE;
			end
			bht_pkg::B_IDLE: begin
				if (q_valid && !q_req.fail) state_d = bht_pkg::B_SCAN;
			end
			bht_pkg::B_SCAN: begin
				if (hit || last) state_d = bht_pkg::B_IDLE;
			end
			default: state_d = bht_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop         = (state_q == bht_pkg::B_IDLE) && q_valid;
		rd_en       = pop || (scanning && !hit && !last);
		raddr       = pop ? base_d : cur_addr + 1'b1;
		we_h        = clearing || (scanning && hit &&
			((op_q == bht_pkg::OP_INSERT) || (op_q == bht_pkg::OP_REMOVE)));
		we_d        = scanning && hit && (op_q == bht_pkg::OP_INSERT);
		waddr       = clearing ? clr_q : cur_addr;
		wdata_h     = (!clearing && (op_q == bht_pkg::OP_INSERT)) ? hash_q : '0;
		res_valid   = (pop && q_req.fail) || (scanning && (hit || last));
		res_success = scanning && hit;
		res_data    = (scanning && hit && (op_q == bht_pkg::OP_FIND)) ? drd_q : '0;
	end

	always_ff @(posedge clk) begin
		if (rd_en) begin
			hrd_q <= hash_mem[raddr];
			drd_q <= data_mem[raddr];
		end
		if (we_h) hash_mem[waddr] <= wdata_h;
		if (we_d) data_mem[waddr] <= data_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= bht_pkg::B_CLEAR;
			clr_q   <= '0;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= res_valid;
			if (clearing) clr_q <= clr_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		success_q <= res_success;
		found_q   <= res_data;
		if (pop) begin
			op_q   <= q_req.op;
			hash_q <= q_req.hash;
			data_q <= q_req.data;
			base_q <= base_d;
			k_q    <= '0;
		end else if (scanning && !hit && !last) begin
			k_q <= k_q + 1'b1;
		end
	end

	assign done       = done_q;
	assign success    = success_q;
	assign found_data = found_q;

endmodule

FILE: rtl/core/bucketed_hash_table_core.sv
// an item passes the front end, the queue and the table engine; a zero hash or
// unknown operation gets its result when popped, other items when a bucket slot
// decides or the last slot misses; the front end takes a new item only when idle,
// after its 8 remainder steps and its push; the engine takes one item at a time,
// one memory read per scanned slot; busy is high while reset clears the hash store
`timescale 1ns / 1ps

`include "assert_macros.svh"

module bucketed_hash_table_core #(
	parameter int SIZE = bht_pkg::SIZE_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	output logic                          busy,
	input  logic [1:0]                    req_type,
	input  logic [bht_pkg::HASH_W-1:0]    key_hash,
	input  logic [bht_pkg::DATA_W-1:0]    data_value,
	output logic                          done,
	output logic                          success,
	output logic [bht_pkg::DATA_W-1:0]    found_data
);

	localparam int IDX_W = $clog2(SIZE);
	localparam int QW    = $bits(bht_pkg::req_t) + IDX_W;

	bht_pkg::req_t     f_req, b_req;
	logic [IDX_W-1:0]  f_bucket, b_bucket;
	logic [QW-1:0]     q_rdata;
	logic              q_push, q_full;
	logic              q_pop, q_empty;
	logic              clearing;

	bht_front #(.SIZE(SIZE)) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.req_type   (req_type),
		.key_hash   (key_hash),
		.data_value (data_value),
		.clearing   (clearing),
		.q_full     (q_full),
		.busy       (busy),
		.push       (q_push),
		.req        (f_req),
		.bucket     (f_bucket)
	);

	bht_queue #(.W(QW), .DEPTH(bht_pkg::QUEUE_DEPTH)) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({f_req, f_bucket}),
		.pop    (q_pop),
		.full   (q_full),
		.empty  (q_empty),
		.rdata  (q_rdata)
	);

	assign {b_req, b_bucket} = q_rdata;

	bht_back #(.SIZE(SIZE)) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (!q_empty),
		.q_req      (b_req),
		.q_bucket   (b_bucket),
		.pop        (q_pop),
		.clearing   (clearing),
		.done       (done),
		.success    (success),
		.found_data (found_data)
	);

	`ASSERT_NEVER(a_no_push_when_full, clk, arst_n, q_push && q_full)
	`ASSERT_NEVER(a_no_result_while_clearing, clk, arst_n, done && clearing)
	`ASSERT_NEXT(a_busy_after_accept, clk, arst_n, start && !busy, busy)
	`ASSERT_IMPLIES(a_pop_needs_entry, clk, arst_n, q_pop, !q_empty)

endmodule

FILE: verif/bucketed_hash_table_core_tb.sv
// self-checking testbench of the bucketed hash table core
`timescale 1ns / 1ps

module bucketed_hash_table_core_tb;

	localparam int SIZE        = 16;
	localparam int SLOTS       = SIZE * SIZE;
	localparam int RAND_ITEMS  = 550;
	localparam int CYCLE_LIMIT = 400000;
	localparam int TAIL_CYCLES = 2 * SIZE + 20;
	localparam logic [1:0] OP_UNKNOWN = 2'd3;

	typedef struct {
		bit        ok;
		bit [31:0] word;
	} reply_t;

	// predicts the table contents and the reply of every accepted item
	class table_board;
		bit [31:0] slot_key[SLOTS];
		bit [31:0] slot_word[SLOTS];
		reply_t    replies[$];
		int        errors;

		function new();
			foreach (slot_key[i]) begin
				slot_key[i]  = '0;
				slot_word[i] = '0;
			end
			errors = 0;
		endfunction

		function int find_slot(int unsigned base, bit [31:0] want);
			for (int k = 0; k < SIZE; k++)
				if (slot_key[base + k] == want)
					return base + k;
			return -1;
		endfunction

		function void note_request(logic [1:0] op, logic [31:0] h, logic [31:0] d);
			reply_t      r;
			int unsigned base;
			int          s;
			r.ok   = 1'b0;
			r.word = '0;
			if (h != '0) begin
				base = (h % SIZE) * SIZE;
				case (op)
					bht_pkg::OP_INSERT: begin
						s = find_slot(base, '0);
						if (s >= 0) begin
							slot_key[s]  = h;
							slot_word[s] = d;
							r.ok = 1'b1;
						end
					end
					bht_pkg::OP_FIND: begin
						s = find_slot(base, h);
						if (s >= 0) begin
							r.word = slot_word[s];
							r.ok   = 1'b1;
						end
					end
					bht_pkg::OP_REMOVE: begin
						s = find_slot(base, h);
						if (s >= 0) begin
							slot_key[s] = '0;
							r.ok = 1'b1;
						end
					end
					default: ;
				endcase
			end
			replies.push_back(r);
		endfunction

		function int pending();
			return replies.size();
		endfunction

		task report(string what);
			errors++;
			if (errors <= 40)
				$display("mismatch at %0t: %s", $realtime, what);
		endtask

		task check_response(logic ok, logic [31:0] fd);
			reply_t r;
			if (replies.size() == 0) begin
				report("result with no item outstanding");
				return;
			end
			r = replies.pop_front();
			if (ok !== r.ok)
				report($sformatf("success %0b, expected %0b", ok, r.ok));
			if (fd !== r.word)
				report($sformatf("found_data %08h, expected %08h", fd, r.word));
		endtask
	endclass

	logic        clk        = 1'b0;
	logic        arst_n     = 1'b0;
	logic        start      = 1'b0;
	logic [1:0]  req_type   = bht_pkg::OP_INSERT;
	logic [31:0] key_hash   = '0;
	logic [31:0] data_value = '0;
	logic        busy;
	logic        done;
	logic        success;
	logic [31:0] found_data;

	table_board  board;
	int          cycles = 0;
	int          burst_left = 0;
	logic [31:0] recent_keys[$];

	bucketed_hash_table_core #(
		.SIZE(SIZE)
	) u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.req_type  (req_type),
		.key_hash  (key_hash),
		.data_value(data_value),
		.done      (done),
		.success   (success),
		.found_data(found_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("CHECK FAILED");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && done)
			board.check_response(success, found_data);
	end

	// holds the item on the ports until an edge sees busy low
	task send_item(logic [1:0] op, logic [31:0] h, logic [31:0] d);
		start      <= 1'b1;
		req_type   <= op;
		key_hash   <= h;
		data_value <= d;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		board.note_request(op, h, d);
	endtask

	task pause(int n);
		if (n > 0) begin
			start <= 1'b0;
			repeat (n) @(posedge clk);
		end
	endtask

	// bursts of back-to-back items, most of them separated by random gaps
	task paced_item(logic [1:0] op, logic [31:0] h, logic [31:0] d);
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 16);
			if ($urandom_range(0, 3) != 0)
				pause($urandom_range(1, 25));
		end
		burst_left--;
		send_item(op, h, d);
	endtask

	task drain_all();
		start <= 1'b0;
		while (board.pending() != 0)
			@(posedge clk);
	endtask

	function logic [31:0] pick_key();
		int sel;
		sel = $urandom_range(0, 99);
		// few buckets and few keys, so buckets fill up and keys repeat
		if (sel < 40)
			return $urandom_range(0, 11) * SIZE + $urandom_range(0, 3);
		if (sel < 70 && recent_keys.size() > 0)
			return recent_keys[$urandom_range(0, recent_keys.size() - 1)];
		if (sel < 92)
			return $urandom;
		if (sel < 96)
			return '0;
		return 32'hFFFF_FFFF ^ $urandom_range(0, 255);
	endfunction

	function logic [1:0] pick_op(int idx);
		int sel;
		int ins_weight;
		sel = $urandom_range(0, 99);
		// alternate fill-heavy and drain-heavy stretches
		ins_weight = ((idx % 200) < 100) ? 55 : 25;
		if (sel < 4)
			return OP_UNKNOWN;
		if (sel < 4 + ins_weight)
			return bht_pkg::OP_INSERT;
		if (sel < 4 + ins_weight + (96 - ins_weight) / 2)
			return bht_pkg::OP_FIND;
		return bht_pkg::OP_REMOVE;
	endfunction

	initial begin
		logic [1:0]  op;
		logic [31:0] h;
		logic [31:0] d;
		board = new();
		repeat (9) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// zero hash fails for every operation
		paced_item(bht_pkg::OP_INSERT, '0, 32'hDEAD_BEEF);
		paced_item(bht_pkg::OP_FIND, '0, '0);
		paced_item(bht_pkg::OP_REMOVE, '0, '0);
		paced_item(bht_pkg::OP_INSERT, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		paced_item(bht_pkg::OP_FIND, 32'hFFFF_FFFF, '0);
		paced_item(OP_UNKNOWN, 32'hFFFF_FFFF, 32'h1234_5678);
		paced_item(bht_pkg::OP_FIND, 32'h0000_0011, '0);
		// fill one bucket with a duplicate key, then overflow it
		paced_item(bht_pkg::OP_INSERT, 32'd5, 32'hA5A5_0001);
		paced_item(bht_pkg::OP_INSERT, 32'd5, 32'hA5A5_0002);
		for (int k = 1; k < SIZE - 1; k++)
			paced_item(bht_pkg::OP_INSERT, 5 + SIZE * k, $urandom);
		paced_item(bht_pkg::OP_INSERT, 5 + SIZE * SIZE, '0);
		// first match wins for find and remove
		paced_item(bht_pkg::OP_FIND, 32'd5, '0);
		paced_item(bht_pkg::OP_REMOVE, 32'd5, '0);
		paced_item(bht_pkg::OP_FIND, 32'd5, '0);
		paced_item(bht_pkg::OP_REMOVE, 32'd5, '0);
		paced_item(bht_pkg::OP_REMOVE, 32'd5, '0);

		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == RAND_ITEMS / 2)
				drain_all();
			op = pick_op(i);
			h  = pick_key();
			case ($urandom_range(0, 9))
				0:       d = '0;
				1:       d = '1;
				default: d = $urandom;
			endcase
			if (op == bht_pkg::OP_INSERT && h != '0) begin
				recent_keys.push_back(h);
				if (recent_keys.size() > 32)
					void'(recent_keys.pop_front());
			end
			paced_item(op, h, d);
		end

		drain_all();
		repeat (TAIL_CYCLES) @(posedge clk);
		if (board.errors == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
